// File: rtl/rrp_pkg.sv
// Package for the relocation patcher: transaction structs, relocation kind codes
// and instruction constants. It has no dependencies.
package rrp_pkg;

  localparam int WordW = 64;
  localparam int OffW  = 3;

  localparam logic [3:0] KIND_ABS64      = 4'd0;
  localparam logic [3:0] KIND_LO12_I     = 4'd1;
  localparam logic [3:0] KIND_LO12_S     = 4'd2;
  localparam logic [3:0] KIND_HI20       = 4'd3;
  localparam logic [3:0] KIND_RELAX      = 4'd4;
  localparam logic [3:0] KIND_CALL       = 4'd5;
  localparam logic [3:0] KIND_RVC_JUMP   = 4'd6;
  localparam logic [3:0] KIND_RVC_BRANCH = 4'd7;
  localparam logic [3:0] KIND_BRANCH     = 4'd8;
  localparam logic [3:0] KIND_JAL        = 4'd9;

  localparam logic [OffW-1:0] OFF_PLACE = 3'd0;
  localparam logic [OffW-1:0] OFF_NEXT  = 3'd4;

  localparam logic [11:0] HI_ROUND     = 12'h800;
  localparam logic [6:0]  OPCODE_AUIPC = 7'h17;

  typedef struct packed {
    logic [3:0]              func;
    logic [WordW-1:0]        symbol_value;
    logic signed [WordW-1:0] addend;
    logic [WordW-1:0]        place_address;
    logic [WordW-1:0]        place_word;
    logic [WordW-1:0]        next_word;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] patched_word;
    logic [OffW-1:0]  byte_offset;
    logic             write_enable;
    logic             error;
    logic             last;
  } out_t;

  typedef struct packed {
    logic        keep_en;
    logic [11:0] keep_val;
  } keep_t;

endpackage

// File: rtl/rrp_patch_calc.sv
// Combinational patch computation for one relocation entry and one result slot.
// Depends on rrp_pkg.
module rrp_patch_calc (
  input  rrp_pkg::in_t   item,
  input  logic [11:0]    kept_low12,
  input  logic           second,
  output rrp_pkg::out_t  res,
  output rrp_pkg::keep_t keep
);
  import rrp_pkg::*;

  logic [WordW-1:0] target;
  logic [WordW-1:0] d;
  logic [31:0]      hi_sum;
  logic [19:0]      hi;

  assign target = item.symbol_value + $unsigned(item.addend);
  assign d      = target - item.place_address;
  assign hi_sum = d[31:0] + {20'd0, HI_ROUND};
  assign hi     = hi_sum[31:12];

  always_comb begin
    res.patched_word = item.place_word;
    res.byte_offset  = OFF_PLACE;
    res.write_enable = 1'b1;
    res.error        = 1'b0;
    res.last         = 1'b1;
    keep.keep_en     = 1'b0;
    keep.keep_val    = d[11:0];
    case (item.func)
      KIND_ABS64: begin
        res.patched_word = target;
      end
      KIND_LO12_I: begin
        res.patched_word[31:20] = kept_low12;
      end
      KIND_LO12_S: begin
        res.patched_word[11:7]  = kept_low12[4:0];
        res.patched_word[31:25] = kept_low12[11:5];
      end
      KIND_HI20: begin
        res.patched_word[31:12] = hi;
        res.patched_word[6:0]   = OPCODE_AUIPC;
        keep.keep_en            = 1'b1;
      end
      KIND_RELAX: begin
        res.write_enable = 1'b0;
      end
      KIND_CALL: begin
        if (!second) begin
          res.patched_word[31:12] = hi;
          res.last                = 1'b0;
          keep.keep_en            = 1'b1;
        end else begin
          res.patched_word        = item.next_word;
          res.patched_word[31:20] = d[11:0];
          res.byte_offset         = OFF_NEXT;
        end
      end
      KIND_RVC_JUMP: begin
        res.patched_word[12:2] = {d[11], d[4], d[9:8], d[10], d[6], d[7], d[3:1], d[5]};
      end
      KIND_RVC_BRANCH: begin
        res.patched_word[12]    = d[8];
        res.patched_word[11:10] = d[4:3];
        res.patched_word[6:5]   = d[7:6];
        res.patched_word[4:3]   = d[2:1];
        res.patched_word[2]     = d[5];
      end
      KIND_BRANCH: begin
        res.patched_word[31:25] = {d[12], d[10:5]};
        res.patched_word[11:7]  = {d[4:1], d[11]};
      end
      KIND_JAL: begin
        res.patched_word[31:12] = {d[20], d[10:1], d[11], d[19:12]};
      end
      default: begin
        res.write_enable = 1'b0;
        res.error        = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/riscv_relocation_patcher_unit.sv
// Top level of the RISC-V relocation patcher: input stage, patch logic, result register.
// Depends on rrp_pkg and rrp_patch_calc.
//
// Usage: present one relocation entry per transaction on in_data with in_valid; it
// is taken at a clock edge where in_stall is low. Results leave on out_data with
// out_valid and are taken where out_stall is low. Each entry gives one result;
// a call entry gives two (place word, then the word at place+4), with last set
// on the final one.
// The entry is registered in the input stage and its result in the result register.
// Throughput: one entry per cycle while out_stall is low; a call entry holds the input
// stage until both of its results have passed through the single result register.
// A stalled receiver holds the result register; the input stage keeps its entry
// and raises in_stall, so at most two entries are in flight.
// Reset (rst_n low, synchronous) empties both stages and clears the kept low
// twelve offset bits used by lo12 entries.
module riscv_relocation_patcher_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rrp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rrp_pkg::out_t out_data
);
  import rrp_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_half_r, s1_half_nxt;
  in_t         s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r;
  logic [11:0] kept_low12_r;

  out_t        calc_res;
  keep_t       calc_keep;
  logic        out_free;
  logic        s1_emit;
  logic        s1_done;
  logic        in_fire;

  rrp_patch_calc u_calc (
    .item       (s1_item_r),
    .kept_low12 (kept_low12_r),
    .second     (s1_half_r),
    .res        (calc_res),
    .keep       (calc_keep)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_emit  = s1_valid_r && out_free;
  assign s1_done  = s1_emit && calc_res.last;
  assign in_stall = s1_valid_r && !s1_done;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_half_nxt   = s1_half_r;
    out_valid_nxt = out_valid_r;
    if (s1_done) begin
      s1_valid_nxt = 1'b0;
      s1_half_nxt  = 1'b0;
    end else if (s1_emit) begin
      s1_half_nxt = 1'b1;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
    if (s1_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s1_half_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      kept_low12_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s1_half_r   <= s1_half_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_emit && calc_keep.keep_en) begin
        kept_low12_r <= calc_keep.keep_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
    if (s1_emit) begin
      out_r <= calc_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_half_is_call: assert property (@(posedge clk) disable iff (!rst_n)
    s1_half_r |-> (s1_valid_r && s1_item_r.func == KIND_CALL))
    else $error("second call result pending without a call entry");

  a_call_second: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_emit && !s1_half_r && s1_item_r.func == KIND_CALL) |=> s1_half_r)
    else $error("call entry did not advance to its second result");

  a_next_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.byte_offset == OFF_NEXT) |-> out_r.last)
    else $error("result at place+4 not marked last");

  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.error) |-> (!out_r.write_enable && out_r.last))
    else $error("error result requests a write");

endmodule
